### rtl/core/swm_pkg.sv
`default_nettype none

package swm_pkg;

    localparam int SWM_WINDOW_MAX   = 64;
    localparam int SWM_SAMPLE_WIDTH = 16;
    localparam int SWM_CFG_WIDTH    = 7;
    localparam logic [SWM_CFG_WIDTH-1:0] SWM_WINDOW_RESET = 7'd3;

    // what every cell does on this clock edge
    typedef struct packed {
        logic insert;
        logic prune;
        logic clear;
        logic delete_en;
    } t_cell_ctl;

    // handed from a cell to its right-hand neighbour, describes the
    // compacted entry at this position (after removal of the oldest sample)
    typedef struct packed {
        logic del_seen;
        logic le;
        logic valid;
    } t_cell_link;

endpackage

`default_nettype wire

### rtl/core/swm_in_if.sv
`default_nettype none

interface swm_in_if import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           last;

    modport source (output valid, output sample, output last, input ready);
    modport sink   (input valid, input sample, input last, output ready);
endinterface

`default_nettype wire

### rtl/core/swm_out_if.sv
`default_nettype none

interface swm_out_if import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) ();
    logic                         valid;
    logic                         ready;
    logic signed [SAMPLE_WIDTH:0] median_x2;

    modport source (output valid, output median_x2, input ready);
    modport sink   (input valid, input median_x2, output ready);
endinterface

`default_nettype wire

### rtl/core/swm_cell.sv
`default_nettype none

module swm_cell import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH,
    parameter int AGE_WIDTH    = $clog2(SWM_WINDOW_MAX)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_cell_ctl                      i_ctl,
    input  logic [AGE_WIDTH-1:0]           i_del_age,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    input  t_cell_link                     i_left_link,
    input  logic signed [SAMPLE_WIDTH-1:0] i_left_value,
    input  logic [AGE_WIDTH-1:0]           i_left_age,
    input  logic signed [SAMPLE_WIDTH-1:0] i_right_value,
    input  logic [AGE_WIDTH-1:0]           i_right_age,
    input  logic                           i_right_valid,
    input  logic                           i_right_le,
    output logic signed [SAMPLE_WIDTH-1:0] o_value,
    output logic [AGE_WIDTH-1:0]           o_age,
    output logic                           o_valid,
    output logic                           o_le,
    output t_cell_link                     o_link,
    output logic signed [SAMPLE_WIDTH-1:0] o_c_value,
    output logic [AGE_WIDTH-1:0]           o_c_age
);

    logic signed [SAMPLE_WIDTH-1:0] r_value;
    logic [AGE_WIDTH-1:0]           r_age;
    logic                           r_valid;
    logic signed [SAMPLE_WIDTH-1:0] n_value;
    logic [AGE_WIDTH-1:0]           n_age;
    logic                           n_valid;
    logic                           w_del;

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_valid = r_valid;
    assign o_le    = r_valid && (r_value <= i_sample);

    // oldest sample leaves, everything to its right moves one place left
    assign w_del           = i_ctl.delete_en && r_valid && (r_age == i_del_age);
    assign o_link.del_seen = i_left_link.del_seen || w_del;
    assign o_link.le       = o_link.del_seen ? i_right_le : o_le;
    assign o_link.valid    = o_link.del_seen ? i_right_valid : r_valid;
    assign o_c_value       = o_link.del_seen ? i_right_value : r_value;
    assign o_c_age         = o_link.del_seen ? i_right_age : r_age;

    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        n_valid = r_valid;
        if (i_ctl.insert) begin
            if (o_link.le) begin
                n_value = o_c_value;
                n_age   = o_c_age + AGE_WIDTH'(1);
                n_valid = 1'b1;
            end else if (i_left_link.le) begin
                // new sample lands here
                n_value = i_sample;
                n_age   = '0;
                n_valid = 1'b1;
            end else begin
                n_value = i_left_value;
                n_age   = i_left_age + AGE_WIDTH'(1);
                n_valid = i_left_link.valid;
            end
        end else if (i_ctl.prune) begin
            n_value = o_c_value;
            n_age   = o_c_age;
            n_valid = o_link.valid;
        end
        if (i_ctl.clear) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

endmodule

`default_nettype wire

### rtl/core/swm_median.sv
`default_nettype none

module swm_median import swm_pkg::*; #(
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH,
    parameter int WINDOW_MAX   = SWM_WINDOW_MAX
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic signed [SAMPLE_WIDTH-1:0] i_values [WINDOW_MAX],
    input  logic [WINDOW_MAX-1:0]          i_sel_lo,
    input  logic [WINDOW_MAX-1:0]          i_sel_hi,
    input  logic                           i_load,
    output logic                           o_blocked,
    swm_out_if.source                      o_res
);

    logic [SAMPLE_WIDTH-1:0]      w_lo;
    logic [SAMPLE_WIDTH-1:0]      w_hi;
    logic signed [SAMPLE_WIDTH:0] w_sum;
    logic                         r_valid;
    logic                         n_valid;
    logic signed [SAMPLE_WIDTH:0] r_median;

    // each cell taps onto an or-bus through its select bit
    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int i = 0; i < WINDOW_MAX; i++) begin
            w_lo = w_lo | (i_values[i] & {SAMPLE_WIDTH{i_sel_lo[i]}});
            w_hi = w_hi | (i_values[i] & {SAMPLE_WIDTH{i_sel_hi[i]}});
        end
    end

    assign w_sum = $signed({w_lo[SAMPLE_WIDTH-1], w_lo}) + $signed({w_hi[SAMPLE_WIDTH-1], w_hi});

    assign o_blocked       = r_valid && !o_res.ready;
    assign o_res.valid     = r_valid;
    assign o_res.median_x2 = r_median;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (o_res.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_median <= w_sum;
        end
    end

endmodule

`default_nettype wire

### rtl/core/sliding_window_median.sv
// a request updates the cells and pending flag, then the median register loads
// throughput: one request per cycle while the window size is unchanged and no pending
// result waits on a stalled output; after the size is lowered below the current fill,
// the oldest samples are dropped one at a time before the next request is accepted
// reset empties the window and sets the window size to 3
`default_nettype none

module sliding_window_median import swm_pkg::*; #(
    parameter int WINDOW_MAX   = SWM_WINDOW_MAX,
    parameter int SAMPLE_WIDTH = SWM_SAMPLE_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [SWM_CFG_WIDTH-1:0] i_cfg_wr_data,
    swm_in_if.sink                   i_req,
    swm_out_if.source                o_res
);

    localparam int CW = $clog2(WINDOW_MAX + 1);
    localparam int AW = $clog2(WINDOW_MAX);
    localparam int KW = (CW > SWM_CFG_WIDTH) ? CW : SWM_CFG_WIDTH;

    logic [SWM_CFG_WIDTH-1:0] r_window_size;
    logic [CW-1:0]            r_fill;
    logic [CW-1:0]            n_fill;
    logic                     r_pend;
    logic                     n_pend;
    logic [WINDOW_MAX-1:0]    r_sel_lo;
    logic [WINDOW_MAX-1:0]    r_sel_hi;
    logic [WINDOW_MAX-1:0]    n_sel_lo;
    logic [WINDOW_MAX-1:0]    n_sel_hi;

    logic [KW-1:0] w_ws;
    logic [KW-1:0] w_k;
    logic [KW-1:0] w_fill;
    logic [KW-1:0] w_fill_after;
    logic [KW-1:0] w_idx_lo;
    logic [KW-1:0] w_idx_hi;
    logic          w_prune_need;
    logic          w_prune_go;
    logic          w_out_blocked;
    logic          w_accept;
    logic          w_do_del;
    logic          w_emit;
    logic [AW-1:0] w_del_age;
    t_cell_ctl     w_ctl;

    logic signed [SAMPLE_WIDTH-1:0] w_value   [WINDOW_MAX];
    logic [AW-1:0]                  w_age     [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]          w_valid;
    logic [WINDOW_MAX-1:0]          w_le;
    t_cell_link                     w_link    [WINDOW_MAX];
    logic signed [SAMPLE_WIDTH-1:0] w_c_value [WINDOW_MAX];
    logic [AW-1:0]                  w_c_age   [WINDOW_MAX];

    assign w_ws   = KW'(r_window_size);
    assign w_k    = (w_ws > KW'(WINDOW_MAX)) ? KW'(WINDOW_MAX) : w_ws;
    assign w_fill = KW'(r_fill);

    // shrunk window: drop oldest samples one per cycle, unless a pending result is stalled, before taking requests
    assign w_prune_need = (w_k != '0) && (w_fill > w_k);
    assign w_prune_go   = w_prune_need && !(r_pend && w_out_blocked);

    assign i_req.ready = !w_prune_need && !(r_pend && w_out_blocked);
    assign w_accept    = i_req.valid && i_req.ready;

    assign w_do_del  = (w_accept && (w_k != '0)) ? (w_fill >= w_k) : w_prune_go;
    assign w_del_age = AW'(r_fill - CW'(1));

    assign w_ctl.insert    = w_accept && (w_k != '0);
    assign w_ctl.prune     = w_prune_go;
    assign w_ctl.clear     = w_accept && i_req.last;
    assign w_ctl.delete_en = w_do_del;

    assign w_fill_after = w_fill - KW'(w_do_del) + KW'(1);
    assign w_emit       = w_ctl.insert && (w_fill_after == w_k);

    always_comb begin
        n_fill = r_fill;
        if (w_ctl.clear) begin
            n_fill = '0;
        end else if (w_ctl.insert) begin
            n_fill = CW'(w_fill_after);
        end else if (w_prune_go) begin
            n_fill = r_fill - CW'(1);
        end
    end

    always_comb begin
        n_pend = r_pend;
        if (w_emit) begin
            n_pend = 1'b1;
        end else if (!w_out_blocked) begin
            n_pend = 1'b0;
        end
    end

    // middle taps: even window sums the two centre entries, odd doubles one
    assign w_idx_hi = w_k >> 1;
    assign w_idx_lo = w_k[0] ? (w_k >> 1) : ((w_k >> 1) - KW'(1));

    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            n_sel_lo[i] = (w_idx_lo == KW'(i));
            n_sel_hi[i] = (w_idx_hi == KW'(i));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_size <= SWM_WINDOW_RESET;
            r_fill        <= '0;
            r_pend        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window_size <= i_cfg_wr_data;
            end
            r_fill <= n_fill;
            r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_lo <= n_sel_lo;
        r_sel_hi <= n_sel_hi;
    end

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        t_cell_link                     w_left_link;
        logic signed [SAMPLE_WIDTH-1:0] w_left_value;
        logic [AW-1:0]                  w_left_age;
        logic signed [SAMPLE_WIDTH-1:0] w_right_value;
        logic [AW-1:0]                  w_right_age;
        logic                           w_right_valid;
        logic                           w_right_le;

        if (g == 0) begin : g_first
            assign w_left_link  = '{del_seen: 1'b0, le: 1'b1, valid: 1'b1};
            assign w_left_value = '0;
            assign w_left_age   = '0;
        end else begin : g_mid
            assign w_left_link  = w_link[g-1];
            assign w_left_value = w_c_value[g-1];
            assign w_left_age   = w_c_age[g-1];
        end

        if (g == WINDOW_MAX - 1) begin : g_end
            assign w_right_value = '0;
            assign w_right_age   = '0;
            assign w_right_valid = 1'b0;
            assign w_right_le    = 1'b0;
        end else begin : g_inner
            assign w_right_value = w_value[g+1];
            assign w_right_age   = w_age[g+1];
            assign w_right_valid = w_valid[g+1];
            assign w_right_le    = w_le[g+1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .AGE_WIDTH    (AW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_ctl),
            .i_del_age     (w_del_age),
            .i_sample      (i_req.sample),
            .i_left_link   (w_left_link),
            .i_left_value  (w_left_value),
            .i_left_age    (w_left_age),
            .i_right_value (w_right_value),
            .i_right_age   (w_right_age),
            .i_right_valid (w_right_valid),
            .i_right_le    (w_right_le),
            .o_value       (w_value[g]),
            .o_age         (w_age[g]),
            .o_valid       (w_valid[g]),
            .o_le          (w_le[g]),
            .o_link        (w_link[g]),
            .o_c_value     (w_c_value[g]),
            .o_c_age       (w_c_age[g])
        );
    end

    swm_median #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .WINDOW_MAX   (WINDOW_MAX)
    ) u_median (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_values  (w_value),
        .i_sel_lo  (r_sel_lo),
        .i_sel_hi  (r_sel_hi),
        .i_load    (r_pend && !w_out_blocked),
        .o_blocked (w_out_blocked),
        .o_res     (o_res)
    );

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= KW'(WINDOW_MAX))
        else $error("fill count above window capacity");

    a_fill_matches_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_valid) == int'(r_fill))
        else $error("fill count disagrees with occupied cells");

    a_cells_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid + WINDOW_MAX'(1)) & w_valid) == '0)
        else $error("occupied cells not packed from the low end");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.last) |=> (r_fill == '0))
        else $error("window not emptied after last request");

    a_pend_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && w_out_blocked) |=> r_pend)
        else $error("pending result lost while output stalled");

endmodule

`default_nettype wire

### sim/sliding_window_median_tb.sv
`timescale 1ns / 100ps

module sliding_window_median_tb;
    import swm_pkg::*;

    typedef logic signed [SWM_SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [SWM_SAMPLE_WIDTH:0]   median_t;

    localparam sample_t SAMPLE_MIN = {1'b1, {(SWM_SAMPLE_WIDTH-1){1'b0}}};
    localparam sample_t SAMPLE_MAX = {1'b0, {(SWM_SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SWM_CFG_WIDTH-1:0] WINDOW_OFF  = '0;
    localparam logic [SWM_CFG_WIDTH-1:0] WINDOW_TOP  = SWM_CFG_WIDTH'(SWM_WINDOW_MAX);
    localparam logic [SWM_CFG_WIDTH-1:0] WINDOW_OVER = '1;

    // sample styles for random sequences
    localparam int unsigned STYLE_CLUSTER  = 0;
    localparam int unsigned STYLE_FULL     = 1;
    localparam int unsigned STYLE_EXTREMES = 2;
    localparam int unsigned STYLE_MIXED    = 3;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_wr_en;
    logic [SWM_CFG_WIDTH-1:0] i_cfg_wr_data;

    swm_in_if  req_if ();
    swm_out_if res_if ();

    sliding_window_median dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_req         (req_if.sink),
        .o_res         (res_if.source)
    );

    // predictor state
    logic [SWM_CFG_WIDTH-1:0] window_size_q;
    sample_t                  arrival_q [$];
    sample_t                  sorted_q [$];
    median_t                  expected_medians [$];

    int          error_count     = 0;
    int          requests_seen   = 0;
    int          medians_checked = 0;
    int          window_writes   = 0;
    bit          tx_gaps_on      = 1'b1;
    bit          rx_stalls_on    = 1'b1;
    int unsigned hold_off_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(25, 60);
    endfunction

    function automatic sample_t random_sample(input int unsigned style);
        int unsigned pick;
        pick = (style == STYLE_MIXED) ? $urandom_range(0, 2) : style;
        case (pick)
            STYLE_CLUSTER: return sample_t'(int'($urandom_range(0, 8)) - 4);
            STYLE_FULL:    return sample_t'($urandom());
            default: begin
                case ($urandom_range(0, 3))
                    0:       return SAMPLE_MIN;
                    1:       return SAMPLE_MAX;
                    2:       return sample_t'(-1);
                    default: return sample_t'(0);
                endcase
            end
        endcase
    endfunction

    function automatic int unsigned pick_window();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return 0;
        else if (r < 12)
            return 1;
        else if (r < 20)
            return 2;
        else if (r < 88)
            return $urandom_range(3, 9);
        else
            return $urandom_range(10, 24);
    endfunction

    // one request through the window: drop oldest down to size-1, insert, take the median once full
    task automatic slide_window(input sample_t s, input logic is_last);
        int unsigned k;
        int          idx;
        sample_t     oldest;
        k = (window_size_q > SWM_WINDOW_MAX) ? SWM_WINDOW_MAX : window_size_q;
        if (k != 0) begin
            while (arrival_q.size() >= k) begin
                oldest = arrival_q.pop_front();
                idx = 0;
                while (idx + 1 < sorted_q.size() && sorted_q[idx] != oldest)
                    idx++;
                sorted_q.delete(idx);
            end
            idx = 0;
            while (idx < sorted_q.size() && sorted_q[idx] <= s)
                idx++;
            sorted_q.insert(idx, s);
            arrival_q.insert(arrival_q.size(), s);
            if (arrival_q.size() == k) begin
                if (k[0])
                    expected_medians.insert(expected_medians.size(),
                                            {sorted_q[k/2], 1'b0});
                else
                    expected_medians.insert(expected_medians.size(),
                                            median_t'(sorted_q[k/2 - 1])
                                            + median_t'(sorted_q[k/2]));
            end
        end
        if (is_last) begin
            arrival_q.delete();
            sorted_q.delete();
        end
    endtask

    always @(posedge i_clk) begin : median_checker
        median_t want;
        if (!i_rst_n) begin
            window_size_q = SWM_WINDOW_RESET;
            arrival_q.delete();
            sorted_q.delete();
            expected_medians.delete();
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_medians.size() == 0) begin
                    $error("median_x2: expected nothing, got %0d", res_if.median_x2);
                    error_count++;
                end else begin
                    want = expected_medians.pop_front();
                    if (res_if.median_x2 !== want) begin
                        $error("median_x2: expected %0d, got %0d", want, res_if.median_x2);
                        error_count++;
                    end
                    medians_checked++;
                end
            end
            // a request on the same edge as a size write still sees the old size
            if (req_if.valid && req_if.ready) begin
                slide_window(req_if.sample, req_if.last);
                requests_seen++;
            end
            if (i_cfg_wr_en)
                window_size_q = i_cfg_wr_data;
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_cycles != 0) begin
                res_if.ready <= 1'b0;
                hold_off_cycles--;
            end else if (stall_left != 0) begin
                res_if.ready <= 1'b0;
                stall_left--;
            end else begin
                res_if.ready <= 1'b1;
                if (rx_stalls_on && $urandom_range(0, 5) == 0)
                    stall_left = gap_len();
            end
        end
    end

    task automatic send_item(input sample_t s, input logic is_last);
        int unsigned gap;
        gap = tx_gaps_on ? gap_len() : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.sample <= s;
        req_if.last   <= is_last;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // stop offering requests and wait until every median is back
    task automatic drain_medians();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_medians.size() != 0)
            @(posedge i_clk);
        // requests that give no median may still be in the pipe
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_window(input logic [SWM_CFG_WIDTH-1:0] size);
        drain_medians();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= size;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        window_writes++;
    endtask

    task automatic test_reset_window();
        // window of 3 straight out of reset
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(sample_t'(-1), 1'b0);
        send_item(sample_t'(0), 1'b1);
    endtask

    task automatic test_pass_through();
        set_window(SWM_CFG_WIDTH'(1));
        send_item(SAMPLE_MIN, 1'b0);
        send_item(SAMPLE_MAX, 1'b1);
    endtask

    task automatic test_even_window();
        set_window(SWM_CFG_WIDTH'(2));
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MAX, 1'b0);
        send_item(SAMPLE_MIN, 1'b0);
        send_item(SAMPLE_MIN, 1'b1);
    endtask

    task automatic test_window_disabled();
        set_window(WINDOW_OFF);
        send_item(sample_t'(5), 1'b0);
        send_item(sample_t'(-5), 1'b1);
    endtask

    task automatic test_shrink_and_grow();
        int i;
        set_window(SWM_CFG_WIDTH'(6));
        for (i = 0; i < 6; i++)
            send_item(random_sample(STYLE_MIXED), 1'b0);
        // shrink mid-sequence: oldest samples get dropped
        set_window(SWM_CFG_WIDTH'(2));
        for (i = 0; i < 2; i++)
            send_item(random_sample(STYLE_FULL), 1'b0);
        // grow mid-sequence: medians pause until the window refills
        set_window(SWM_CFG_WIDTH'(5));
        for (i = 0; i < 4; i++)
            send_item(random_sample(STYLE_CLUSTER), i == 3);
    endtask

    task automatic test_full_window();
        int i;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        set_window(WINDOW_TOP);
        for (i = 0; i < SWM_WINDOW_MAX + 2; i++)
            send_item(random_sample(STYLE_MIXED), 1'b0);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        // anything above the maximum behaves as the maximum
        set_window(WINDOW_OVER);
        for (i = 0; i < 4; i++)
            send_item(random_sample(STYLE_FULL), i == 3);
    endtask

    task automatic test_backpressure();
        int i;
        set_window(SWM_CFG_WIDTH'(3));
        tx_gaps_on = 1'b0;
        hold_off_cycles = 200;
        for (i = 0; i < 40; i++)
            send_item(random_sample(STYLE_FULL), i == 39);
        tx_gaps_on = 1'b1;
        drain_medians();
    endtask

    task automatic test_random_sequences(input int unsigned budget);
        int unsigned sent;
        int unsigned k;
        int unsigned len;
        int unsigned style;
        bit          close_seq;
        int unsigned i;
        sent = 0;
        while (sent < budget) begin
            k = pick_window();
            set_window(k[SWM_CFG_WIDTH-1:0]);
            tx_gaps_on   = ($urandom_range(0, 3) != 0);
            rx_stalls_on = ($urandom_range(0, 3) != 0);
            style        = $urandom_range(0, 3);
            if (k == 0)
                len = $urandom_range(1, 4);
            else if ($urandom_range(0, 99) < 80)
                len = $urandom_range(k, 3 * k + 4);
            else
                len = $urandom_range(1, k);
            // an open sequence carries over into the next window size
            close_seq = ($urandom_range(0, 99) < 85);
            for (i = 0; i < len; i++)
                send_item(random_sample(style),
                          (i == len - 1) ? close_seq : ($urandom_range(0, 49) == 0));
            if (k != 0)
                sent += len;
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    initial begin
        int unsigned waited;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = SWM_WINDOW_RESET;
        req_if.valid  = 1'b0;
        req_if.sample = '0;
        req_if.last   = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_window();
        test_pass_through();
        test_even_window();
        test_window_disabled();
        test_shrink_and_grow();
        test_full_window();
        test_backpressure();
        test_random_sequences(320);

        req_if.valid <= 1'b0;
        waited = 0;
        while (expected_medians.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (4) @(posedge i_clk);
        if (expected_medians.size() != 0) begin
            $error("median_x2: %0d expected results never arrived", expected_medians.size());
            error_count++;
        end

        $display("run covered %0d requests and %0d medians over %0d window size writes",
                 requests_seen, medians_checked, window_writes);
        $display("sizes 0 to 127, odd and even, shrink and grow mid-sequence, long hold-off");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
